// ===== sv/agkf_pkg.sv =====
// agkf_pkg: shared types and constants for the angle / gyro-bias kalman filter
// no dependencies
package agkf_pkg;

  localparam int unsigned W = 32;
  localparam int unsigned FRAC = 30;
  localparam logic signed [W-1:0] ONE_Q30 = 32'sd1073741824;
  localparam logic signed [W-1:0] SMAX = 32'sh7fffffff;
  localparam logic signed [W-1:0] SMIN = 32'sh80000000;

  localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;
  localparam logic [1:0] REG_STEP_TIME   = 2'd3;

  localparam logic [30:0] RST_ANGLE_NOISE = 31'd1073742;
  localparam logic [30:0] RST_BIAS_NOISE  = 31'd3221225;
  localparam logic [30:0] RST_MEAS_NOISE  = 31'd536870912;
  localparam logic [30:0] RST_STEP_TIME   = 31'd5368709;

  // saturate a 34-bit sum to 32 bits
  function automatic logic signed [W-1:0] sat34(input logic signed [W+1:0] v);
    logic signed [W-1:0] r;
    if (v > 34'sh07fffffff) r = SMAX;
    else if (v < -34'sh080000000) r = SMIN;
    else r = v[W-1:0];
    return r;
  endfunction

  // round half up, shift by 30, saturate a 64-bit product
  function automatic logic signed [W-1:0] qround(input logic signed [63:0] p);
    logic signed [63:0] s;
    logic signed [W-1:0] r;
    s = (p + 64'sd536870912) >>> FRAC;
    if (s > 64'sh7fffffff) r = SMAX;
    else if (s < -64'sh80000000) r = SMIN;
    else r = s[W-1:0];
    return r;
  endfunction

  typedef struct packed {
    logic start;
    logic signed [W-1:0] num;
    logic signed [W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic signed [W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== sv/agkf_if.sv =====
// agkf_if: valid/ready channel carrying two signed 32-bit fields
// depends on agkf_pkg
interface agkf_if;
  logic valid;
  logic ready;
  logic signed [agkf_pkg::W-1:0] f0;
  logic signed [agkf_pkg::W-1:0] f1;
  modport source (output valid, output f0, output f1, input ready);
  modport sink (input valid, input f0, input f1, output ready);
endinterface

// ===== sv/agkf_div.sv =====
// agkf_div: restoring divider, one quotient bit per cycle, (num*2^30)/den
// truncated toward zero and saturated; zero divisor gives zero
// depends on agkf_pkg
module agkf_div (
  input  logic clk,
  input  logic rst_n,
  input  agkf_pkg::div_req_t req,
  output agkf_pkg::div_rsp_t rsp
);
  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [61:0] num_r, num_nxt;
  logic [62:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic        neg_r, neg_nxt, zero_r, zero_nxt, done_r, done_nxt;
  logic [32:0] trial;
  logic [33:0] diff;
  logic signed [63:0] sq;

  always_comb begin
    busy_nxt = busy_r; cnt_nxt = cnt_r; num_nxt = num_r; quo_nxt = quo_r;
    rem_nxt = rem_r; den_nxt = den_r; neg_nxt = neg_r; zero_nxt = zero_r;
    done_nxt = 1'b0;
    trial = {rem_r[31:0], num_r[61]};
    diff = {1'b0, trial} - {2'b00, den_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt = 6'd0;
      num_nxt = {(req.num[31] ? 32'(-req.num) : req.num), 30'd0};
      den_nxt = req.den[31] ? 32'(-req.den) : req.den;
      neg_nxt = req.num[31] ^ req.den[31];
      zero_nxt = (req.den == '0);
      rem_nxt = '0;
      quo_nxt = '0;
    end else if (busy_r) begin
      if (!diff[33]) begin
        rem_nxt = diff[32:0];
        quo_nxt = {quo_r[61:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[61:0], 1'b0};
      end
      num_nxt = {num_r[60:0], 1'b0};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd61) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt; quo_r <= quo_nxt; rem_r <= rem_nxt;
    den_r <= den_nxt; neg_r <= neg_nxt; zero_r <= zero_nxt;
  end

  always_comb begin
    sq = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    rsp.done = done_r;
    if (zero_r) rsp.quo = '0;
    else if (sq > 64'sh7fffffff) rsp.quo = agkf_pkg::SMAX;
    else if (sq < -64'sh80000000) rsp.quo = agkf_pkg::SMIN;
    else rsp.quo = sq[31:0];
  end
endmodule

// ===== sv/angle_gyro_kalman_filter.sv =====
// angle_gyro_kalman_filter: top level, sequencer over one shared multiplier
// depends on agkf_pkg, agkf_if, agkf_div
// one request runs the whole kalman step. eleven multiply steps (select operands,
// then accumulate) share one registered 32x32 multiplier, and two divider passes
// (start, 62 quotient bits, done) produce the gains. the result is then held valid
// until ready takes it, and most of the time per request goes to the divider passes;
// an output stall delays the next accept. the block takes no new request until the
// result has been taken.
// configuration writes are taken at any time but must only happen while idle.
module angle_gyro_kalman_filter (
  input  logic clk,
  input  logic rst_n,
  agkf_if.sink   in_ch,
  agkf_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_MUL = 6'b000010, S_ACC = 6'b000100,
    S_DIV = 6'b001000, S_DWAIT = 6'b010000, S_OUT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] op_r, op_nxt;
  logic       dsel_r, dsel_nxt;

  logic [30:0] qa_r, qb_r, rm_r, dt_r;
  logic signed [31:0] ang_r, bias_r, aa_r, ab_r, ba_r, bb_r;
  logic signed [31:0] ang_nxt, bias_nxt, aa_nxt, ab_nxt, ba_nxt, bb_nxt;
  logic signed [31:0] acc_r, gyr_r, rate_r, err_r, k0_r, k1_r, t0_r, t1_r;
  logic signed [31:0] acc_nxt, gyr_nxt, rate_nxt, err_nxt, k0_nxt, k1_nxt, t0_nxt, t1_nxt;
  logic signed [31:0] ma, mb, q;
  logic signed [63:0] prod_r;
  agkf_pkg::div_req_t dreq;
  agkf_pkg::div_rsp_t drsp;
  logic signed [31:0] oa_r, or_r;

  agkf_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qa_r <= agkf_pkg::RST_ANGLE_NOISE; qb_r <= agkf_pkg::RST_BIAS_NOISE;
      rm_r <= agkf_pkg::RST_MEAS_NOISE;  dt_r <= agkf_pkg::RST_STEP_TIME;
    end else if (cfg_we) begin
      unique case (cfg_index)
        agkf_pkg::REG_ANGLE_NOISE: qa_r <= cfg_data;
        agkf_pkg::REG_BIAS_NOISE:  qb_r <= cfg_data;
        agkf_pkg::REG_MEAS_NOISE:  rm_r <= cfg_data;
        agkf_pkg::REG_STEP_TIME:   dt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand select per sequencer step
  always_comb begin
    case (op_r)
      4'd0: begin ma = rate_r; mb = {1'b0, dt_r}; end
      4'd1: begin
        ma = agkf_pkg::sat34(34'(signed'({1'b0, qa_r})) - 34'(ab_r) - 34'(ba_r));
        mb = {1'b0, dt_r};
      end
      4'd2: begin ma = agkf_pkg::sat34(-34'(bb_r)); mb = {1'b0, dt_r}; end
      4'd3: begin ma = agkf_pkg::sat34(-34'(bb_r)); mb = {1'b0, dt_r}; end
      4'd4: begin ma = {1'b0, qb_r}; mb = {1'b0, dt_r}; end
      4'd5: begin ma = k0_r; mb = t0_r; end
      4'd6: begin ma = k0_r; mb = t1_r; end
      4'd7: begin ma = k1_r; mb = t0_r; end
      4'd8: begin ma = k1_r; mb = t1_r; end
      4'd9: begin ma = k0_r; mb = err_r; end
      default: begin ma = k1_r; mb = err_r; end
    endcase
  end

  always_ff @(posedge clk) prod_r <= ma * mb;
  assign q = agkf_pkg::qround(prod_r);

  always_comb begin
    state_nxt = state_r; op_nxt = op_r; dsel_nxt = dsel_r;
    ang_nxt = ang_r; bias_nxt = bias_r; aa_nxt = aa_r; ab_nxt = ab_r;
    ba_nxt = ba_r; bb_nxt = bb_r; acc_nxt = acc_r; gyr_nxt = gyr_r;
    rate_nxt = rate_r; err_nxt = err_r; k0_nxt = k0_r; k1_nxt = k1_r;
    t0_nxt = t0_r; t1_nxt = t1_r;
    dreq.start = 1'b0;
    dreq.num = dsel_r ? ba_r : aa_r;
    dreq.den = agkf_pkg::sat34(34'(signed'({1'b0, rm_r})) + 34'(aa_r));
    unique case (state_r)
      S_IDLE: if (in_ch.valid) begin
        acc_nxt = in_ch.f0; gyr_nxt = in_ch.f1;
        rate_nxt = agkf_pkg::sat34(34'(in_ch.f1) - 34'(bias_r));
        op_nxt = 4'd0; state_nxt = S_MUL;
      end
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        state_nxt = S_MUL;
        op_nxt = op_r + 4'd1;
        case (op_r)
          4'd0: ang_nxt = agkf_pkg::sat34(34'(ang_r) + 34'(q));
          4'd1: aa_nxt = agkf_pkg::sat34(34'(aa_r) + 34'(q));
          4'd2: ab_nxt = agkf_pkg::sat34(34'(ab_r) + 34'(q));
          4'd3: ba_nxt = agkf_pkg::sat34(34'(ba_r) + 34'(q));
          4'd4: begin
            bb_nxt = agkf_pkg::sat34(34'(bb_r) + 34'(q));
            err_nxt = agkf_pkg::sat34(34'(acc_r) - 34'(ang_r));
            t0_nxt = aa_r; t1_nxt = ab_r;
            dsel_nxt = 1'b0;
            state_nxt = S_DIV;
          end
          4'd5: aa_nxt = agkf_pkg::sat34(34'(aa_r) - 34'(q));
          4'd6: ab_nxt = agkf_pkg::sat34(34'(ab_r) - 34'(q));
          4'd7: ba_nxt = agkf_pkg::sat34(34'(ba_r) - 34'(q));
          4'd8: bb_nxt = agkf_pkg::sat34(34'(bb_r) - 34'(q));
          4'd9: ang_nxt = agkf_pkg::sat34(34'(ang_r) + 34'(q));
          default: begin
            bias_nxt = agkf_pkg::sat34(34'(bias_r) + 34'(q));
            state_nxt = S_OUT;
          end
        endcase
      end
      S_DIV: begin
        // divider uses pre-correction cov_aa and cov_ba as numerators, and cov_aa for the variance too
        dreq.start = 1'b1;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: if (drsp.done) begin
        if (!dsel_r) begin
          k0_nxt = drsp.quo; dsel_nxt = 1'b1; state_nxt = S_DIV;
        end else begin
          k1_nxt = drsp.quo; state_nxt = S_MUL;
        end
      end
      S_OUT: if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; op_r <= '0; dsel_r <= 1'b0;
      ang_r <= '0; bias_r <= '0; aa_r <= agkf_pkg::ONE_Q30; ab_r <= '0;
      ba_r <= '0; bb_r <= agkf_pkg::ONE_Q30;
    end else begin
      state_r <= state_nxt; op_r <= op_nxt; dsel_r <= dsel_nxt;
      ang_r <= ang_nxt; bias_r <= bias_nxt; aa_r <= aa_nxt; ab_r <= ab_nxt;
      ba_r <= ba_nxt; bb_r <= bb_nxt;
    end
    acc_r <= acc_nxt; gyr_r <= gyr_nxt; rate_r <= rate_nxt; err_r <= err_nxt;
    k0_r <= k0_nxt; k1_r <= k1_nxt; t0_r <= t0_nxt; t1_r <= t1_nxt;
    oa_r <= ang_nxt;
    or_r <= agkf_pkg::sat34(34'(gyr_r) - 34'(bias_nxt));
  end

  // result held while waiting, since state does not change in S_OUT
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.f0 = oa_r;
  assign out_ch.f1 = or_r;

`ifndef SYNTHESIS
  a_div_only_wait: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> state_r == S_DWAIT) else $error("divider done outside wait");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(oa_r) && $stable(or_r))
    else $error("result changed while stalled");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
`endif
endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench for the angle / gyro-bias kalman filter
// depends on agkf_pkg, agkf_if and angle_gyro_kalman_filter; runs directed and random
// requests through a bit-exact fixed-point predictor, checks every result in order
module tb_top;

  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
  } filt_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  agkf_if in_ch ();
  agkf_if out_ch ();

  angle_gyro_kalman_filter dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state and its copy of the registers
  logic [30:0] q_angle, q_bias, q_meas, q_dt;
  logic signed [31:0] est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;

  filt_out_t expected_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int sent = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit quiet = 1'b0;    // no idling in the last part of the run

  function automatic logic signed [31:0] sat(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // product scaled back by 2^30, rounding half up
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b) + 66'sd536870912;
    return sat(p >>> 30);
  endfunction

  // gain quotient truncated toward zero, zero for a zero divisor
  function automatic logic signed [31:0] fx_div(input logic signed [31:0] n,
                                                input logic signed [31:0] d);
    logic signed [65:0] nn;
    if (d == 0) return '0;
    nn = 66'(n) <<< 30;
    return sat(nn / 66'(d));
  endfunction

  task automatic reset_predictor();
    q_angle = agkf_pkg::RST_ANGLE_NOISE; q_bias = agkf_pkg::RST_BIAS_NOISE;
    q_meas = agkf_pkg::RST_MEAS_NOISE;   q_dt = agkf_pkg::RST_STEP_TIME;
    est_angle = '0; est_bias = '0;
    p_aa = agkf_pkg::ONE_Q30; p_ab = '0; p_ba = '0; p_bb = agkf_pkg::ONE_Q30;
  endtask

  // one kalman step on the predictor, result queued
  task automatic kalman_step(input logic signed [31:0] accel, input logic signed [31:0] gyro);
    logic signed [31:0] dt, rate, d_aa, d_off, err, var_i, k0, k1, t0, t1;
    filt_out_t r;
    dt = {1'b0, q_dt};
    rate = sat(66'(gyro) - 66'(est_bias));
    est_angle = sat(66'(est_angle) + 66'(fx_mul(rate, dt)));
    d_aa = sat(66'(signed'({1'b0, q_angle})) - 66'(p_ab) - 66'(p_ba));
    d_off = sat(-66'(p_bb));
    p_aa = sat(66'(p_aa) + 66'(fx_mul(d_aa, dt)));
    p_ab = sat(66'(p_ab) + 66'(fx_mul(d_off, dt)));
    p_ba = sat(66'(p_ba) + 66'(fx_mul(d_off, dt)));
    p_bb = sat(66'(p_bb) + 66'(fx_mul(signed'({1'b0, q_bias}), dt)));
    err = sat(66'(accel) - 66'(est_angle));
    var_i = sat(66'(signed'({1'b0, q_meas})) + 66'(p_aa));
    k0 = fx_div(p_aa, var_i);
    k1 = fx_div(p_ba, var_i);
    t0 = p_aa; t1 = p_ab;
    p_aa = sat(66'(p_aa) - 66'(fx_mul(k0, t0)));
    p_ab = sat(66'(p_ab) - 66'(fx_mul(k0, t1)));
    p_ba = sat(66'(p_ba) - 66'(fx_mul(k1, t0)));
    p_bb = sat(66'(p_bb) - 66'(fx_mul(k1, t1)));
    est_angle = sat(66'(est_angle) + 66'(fx_mul(k0, err)));
    est_bias = sat(66'(est_bias) + 66'(fx_mul(k1, err)));
    r.angle = est_angle;
    r.rate = sat(66'(gyro) - 66'(est_bias));
    expected_q.push_back(r);
  endtask

  // send one request; unless quiet, sometimes hold valid low at first, until the
  // block is ready
  task automatic send_sample(input logic signed [31:0] accel, input logic signed [31:0] gyro);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      repeat ($urandom_range(0, 2)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.f0 <= accel;
    in_ch.f1 <= gyro;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    kalman_step(accel, gyro);
    sent++;
  endtask

  // wait for all results, then let the block settle before a register write
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      agkf_pkg::REG_ANGLE_NOISE: q_angle = val;
      agkf_pkg::REG_BIAS_NOISE:  q_bias = val;
      agkf_pkg::REG_MEAS_NOISE:  q_meas = val;
      default:                   q_dt = val;
    endcase
  endtask

  function automatic logic signed [31:0] rnd_q16();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h00c80000)) - 32'sh00640000;
    endcase
  endfunction

  // receiver: random bursts of ready held low (none when quiet), checks each result
  // against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %0d %0d", out_ch.f0, out_ch.f1);
        end else begin
          filt_out_t e;
          e = expected_q.pop_front();
          if (e.angle !== out_ch.f0 || e.rate !== out_ch.f1) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected angle %0d rate %0d, got angle %0d rate %0d",
                       e.angle, e.rate, out_ch.f0, out_ch.f1);
          end
        end
      end
      if (quiet) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left <= int'($urandom_range(0, 2));
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("watchdog expired after %0d requests", sent);
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_defaults();
    send_sample(0, 0);
    send_sample(32'sh7fffffff, 32'sh7fffffff);
    send_sample(32'sh80000000, 32'sh80000000);
    send_sample(32'sh7fffffff, 32'sh80000000);
    send_sample(32'sh80000000, 32'sh7fffffff);
    send_sample(32'sh00010000, -32'sh00010000);
    send_sample(-1, 32'sh55555555);
    send_sample(32'shaaaaaaaa, -1);
    drain();
  endtask

  // zero innovation variance and saturated register extremes
  task automatic test_register_extremes();
    write_reg(agkf_pkg::REG_MEAS_NOISE, 31'd0);
    write_reg(agkf_pkg::REG_ANGLE_NOISE, 31'd0);
    write_reg(agkf_pkg::REG_STEP_TIME, 31'd0);
    write_reg(agkf_pkg::REG_BIAS_NOISE, 31'd0);
    repeat (4) send_sample(rnd_q16(), rnd_q16());
    drain();
    write_reg(agkf_pkg::REG_ANGLE_NOISE, 31'h7fffffff);
    write_reg(agkf_pkg::REG_BIAS_NOISE, 31'h7fffffff);
    write_reg(agkf_pkg::REG_MEAS_NOISE, 31'h7fffffff);
    write_reg(agkf_pkg::REG_STEP_TIME, 31'h7fffffff);
    repeat (8) send_sample(rnd_q16(), rnd_q16());
    drain();
  endtask

  task automatic test_random(input int n, input bit rand_regs);
    if (rand_regs) begin
      write_reg(agkf_pkg::REG_ANGLE_NOISE, 31'($urandom_range(0, 32'h00400000)));
      write_reg(agkf_pkg::REG_BIAS_NOISE, 31'($urandom_range(0, 32'h00400000)));
      write_reg(agkf_pkg::REG_MEAS_NOISE, 31'($urandom_range(0, 32'h7fffffff)));
      write_reg(agkf_pkg::REG_STEP_TIME, 31'($urandom_range(0, 32'h02000000)));
    end
    repeat (n) send_sample(rnd_q16(), rnd_q16());
    drain();
  endtask

  task automatic test_nominal();
    write_reg(agkf_pkg::REG_ANGLE_NOISE, agkf_pkg::RST_ANGLE_NOISE);
    write_reg(agkf_pkg::REG_BIAS_NOISE, agkf_pkg::RST_BIAS_NOISE);
    write_reg(agkf_pkg::REG_MEAS_NOISE, agkf_pkg::RST_MEAS_NOISE);
    write_reg(agkf_pkg::REG_STEP_TIME, agkf_pkg::RST_STEP_TIME);
    repeat (300) send_sample(rnd_q16(), rnd_q16());
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.f0 = '0;
    in_ch.f1 = '0;
    reset_predictor();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_register_extremes();
    for (int i = 0; i < 6; i++) test_random(120, 1'b1);
    test_nominal();
    quiet = 1'b1;
    test_random(250, 1'b1);
    repeat (200) @(posedge clk);
    $display("sent %0d requests, checked %0d results over default, extreme and random",
             sent, results_seen);
    $display("register settings, %0d mismatches", mismatches);
    if (mismatches == 0 && expected_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/agkf_pkg.sv
sv/agkf_if.sv
sv/agkf_div.sv
sv/angle_gyro_kalman_filter.sv
test/tb_top.sv
